@@ hdl/bser_pkg.sv @@
// ---------------------------------------------------------------------------
// bser_pkg: shared types and constants for the BSER value skipper
// Word structs, parse phases and frame kinds used by front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none
package bser_pkg;
  localparam int unsigned MAX_NEST_DEF = 16;
  localparam logic [4:0] MAX_DEPTH_RESET = 5'd16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } bser_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  error_code;
    logic [4:0]  nest_level;
    logic [63:0] int_value;
    logic        int_valid;
  } bser_out_t;

  typedef enum logic [2:0] {
    PH_MARKER, PH_INTMARK, PH_INTBYTES, PH_SKIP, PH_TARRAY, PH_DISCARD
  } phase_t;

  typedef enum logic [2:0] {
    PU_PLAIN, PU_STR, PU_ARR, PU_OBJ, PU_TKEY, PU_TOBJ
  } purpose_t;

  typedef enum logic [1:0] {K_ARR, K_OBJ, K_TKEYS, K_TVALS} kind_t;

  typedef enum logic [1:0] {
    ST_MORE = 2'd0, ST_DONE = 2'd1, ST_ERR = 2'd2, ST_DISC = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    E_NONE = 3'd0, E_MARKER = 3'd1, E_INTMARK = 3'd2, E_NEG = 3'd3,
    E_DEEP = 3'd4, E_TRUNC = 3'd5, E_TMPL = 3'd6, E_OVF = 3'd7
  } err_t;

  localparam logic [7:0] M_ARRAY = 8'h00;
  localparam logic [7:0] M_OBJECT = 8'h01;
  localparam logic [7:0] M_STRING = 8'h02;
  localparam logic [7:0] M_INT8 = 8'h03;
  localparam logic [7:0] M_INT64 = 8'h06;
  localparam logic [7:0] M_REAL = 8'h07;
  localparam logic [7:0] M_TRUE = 8'h08;
  localparam logic [7:0] M_FALSE = 8'h09;
  localparam logic [7:0] M_NULL = 8'h0a;
  localparam logic [7:0] M_TEMPLATE = 8'h0b;
  localparam logic [7:0] M_SKIP = 8'h0c;
endpackage
`default_nettype wire

@@ hdl/bser_value_skipper.sv @@
// ---------------------------------------------------------------------------
// bser_value_skipper: BSER value structure walker
//   channel  | ports                         | word
//   in       | in_valid/in_ready/in_data     | bser_in_t
//   out      | out_valid/out_ready/out_data  | bser_out_t
//   cfg      | cfg_we/cfg_data               | max_depth
// A byte passes through the queue and then the walker; each finished
// frame is popped in turn, and a template object count goes through the
// multiply, built from four 32x32 partial products. Reset is synchronous
// and clears control state; frame stores are written before read. A stalled
// result stalls the walker while the input queue takes words until full.
// ---------------------------------------------------------------------------
`default_nettype none
module bser_value_skipper #(
  parameter int unsigned MAX_NEST = bser_pkg::MAX_NEST_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  bser_pkg::bser_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output bser_pkg::bser_out_t out_data,
  input  wire                 cfg_we,
  input  wire [4:0]           cfg_data
);
  import bser_pkg::*;

  logic       q_valid, q_ready;
  bser_in_t   q_data;
  logic [4:0] depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) depth_r <= MAX_DEPTH_RESET;
    else if (cfg_we) depth_r <= cfg_data;
  end

  bser_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  bser_back #(.MAX_NEST(MAX_NEST)) u_back (
    .clk, .rst_n, .max_depth(depth_r), .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped under stall");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_ERR |-> out_data.nest_level == 5'd0)
    else $error("stack not cleared on error");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_ERR |-> out_data.error_code == E_NONE)
    else $error("error code without error");
endmodule
`default_nettype wire

@@ hdl/bser_front.sv @@
// ---------------------------------------------------------------------------
// bser_front: input word queue
// Two-entry queue that takes input words and hands them to the back end.
// ---------------------------------------------------------------------------
`default_nettype none
module bser_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  bser_pkg::bser_in_t  in_data,
  output logic                q_valid,
  input  wire                 q_ready,
  output bser_pkg::bser_in_t  q_data
);
  import bser_pkg::*;

  bser_in_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem_r[wp_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule
`default_nettype wire

@@ hdl/bser_back.sv @@
// ---------------------------------------------------------------------------
// bser_back: structure walker
// Decodes one byte, keeps the frame stack and pops finished frames one per
// cycle, then presents the result word in an output register.
// ---------------------------------------------------------------------------
`default_nettype none
module bser_back #(
  parameter int unsigned MAX_NEST = bser_pkg::MAX_NEST_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire [4:0]           max_depth,
  input  wire                 q_valid,
  output logic                q_ready,
  input  bser_pkg::bser_in_t  q_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output bser_pkg::bser_out_t out_data
);
  import bser_pkg::*;

  localparam int unsigned AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
  localparam int unsigned TW = $clog2(MAX_NEST + 1);

  // Frame stores
  logic [63:0] rem_mem [MAX_NEST];
  kind_t       kind_mem [MAX_NEST];
  logic [63:0] kc_mem [MAX_NEST];

  logic [TW-1:0] top_r, top_nxt;
  phase_t        ph_r, ph_nxt;
  purpose_t      pu_r, pu_nxt;
  logic [63:0]   left_r, left_nxt;
  logic [63:0]   asm_r, asm_nxt;
  logic [3:0]    size_r, size_nxt;
  logic          pop_r, pop_nxt;     // walking finished frames
  logic          last_r, last_nxt;
  logic [63:0]   ival_r, ival_nxt;
  logic          iv_r, iv_nxt;
  logic          ov_r, ov_nxt;
  bser_out_t     od_r, od_nxt;

  // Multiply: operands registered, one 32x32 partial product per cycle
  logic          mul_r, mul_nxt;
  logic [2:0]    mstep_r;
  logic [127:0]  prod_r;
  logic [63:0]   ma_r, mb_r;
  logic [31:0]   pa, pb;
  logic [63:0]   pp;
  logic [127:0]  pp_sh;

  logic [TW-1:0] limit;
  logic [AW-1:0] ti;
  logic [63:0]   trem, tkc;
  kind_t         tkind;

  logic          wr_en;
  logic [AW-1:0] wr_a;
  logic [63:0]   wr_rem, wr_kc;
  kind_t         wr_kind;
  logic          wr_kcen;

  logic          busy;

  always_comb begin
    if (32'(max_depth) < MAX_NEST) begin
      limit = TW'(max_depth);
    end else begin
      limit = TW'(MAX_NEST);
    end
    ti    = AW'(top_r - TW'(1));
    trem  = rem_mem[ti];
    tkc   = kc_mem[ti];
    tkind = kind_mem[ti];
  end

  always_comb begin
    pa = mstep_r[1] ? ma_r[63:32] : ma_r[31:0];
    pb = mstep_r[0] ? mb_r[63:32] : mb_r[31:0];
    pp = 64'(pa) * 64'(pb);
    case (mstep_r[1:0]) inside
      2'd0: pp_sh = {64'd0, pp};
      2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  assign busy    = pop_r || mul_r || (ov_r && !out_ready);
  assign q_ready = !busy;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    logic [7:0]  b;
    logic        lst;
    logic        fin;
    logic [2:0]  err;
    logic [1:0]  st;
    logic        emit;
    logic [63:0] v;
    logic [63:0] r1;
    logic [2:0]  pos;
    b = q_data.data_byte;
    lst = q_data.last_byte;
    fin = 1'b0;
    err = E_NONE;
    st = ST_MORE;
    emit = 1'b0;
    v = '0;
    r1 = '0;
    pos = '0;
    top_nxt = top_r; ph_nxt = ph_r; pu_nxt = pu_r; left_nxt = left_r;
    asm_nxt = asm_r; size_nxt = size_r; pop_nxt = 1'b0; last_nxt = last_r;
    ival_nxt = ival_r; iv_nxt = iv_r; mul_nxt = 1'b0;
    ov_nxt = ov_r && !out_ready; od_nxt = od_r;
    wr_en = 1'b0; wr_a = ti; wr_rem = trem; wr_kc = '0; wr_kind = tkind;
    wr_kcen = 1'b0;

    if (pop_r) begin
      // one frame per cycle
      fin = 1'b1;
      lst = last_r;
    end else if (mul_r) begin
      lst = last_r;
      // wait for all four partial products
      if (mstep_r == 3'd4) begin
        if (prod_r[127:64] != '0) begin
          err = E_OVF;
        end else if (prod_r[63:0] == '0) begin
          top_nxt = top_r - TW'(1);
          pop_nxt = 1'b1;
        end else begin
          wr_en = 1'b1; wr_kind = K_TVALS; wr_rem = prod_r[63:0];
          emit = 1'b1;
        end
        if (err != E_NONE) emit = 1'b1;
      end
    end else if (q_valid && q_ready) begin
      last_nxt = lst;
      iv_nxt = 1'b0;
      ival_nxt = '0;
      emit = 1'b1;
      unique case (ph_r)
        PH_MARKER: begin
          if (b == M_ARRAY) begin
            pu_nxt = PU_ARR; ph_nxt = PH_INTMARK;
          end else if (b == M_OBJECT) begin
            pu_nxt = PU_OBJ; ph_nxt = PH_INTMARK;
          end else if (b == M_STRING) begin
            pu_nxt = PU_STR; ph_nxt = PH_INTMARK;
          end else if (b >= M_INT8 && b <= M_INT64) begin
            pu_nxt = PU_PLAIN;
            size_nxt = 4'd1 << b[1:0] - 2'd3;
            left_nxt = 64'(4'd1 << (b[1:0] - 2'd3));
            asm_nxt = '0; ph_nxt = PH_INTBYTES;
          end else if (b == M_REAL) begin
            left_nxt = 64'd8; ph_nxt = PH_SKIP;
          end else if (b == M_TRUE || b == M_FALSE || b == M_NULL || b == M_SKIP) begin
            fin = 1'b1;
          end else if (b == M_TEMPLATE) begin
            if (top_r >= limit) err = E_DEEP;
            else begin
              wr_en = 1'b1; wr_a = AW'(top_r); wr_kind = K_TKEYS; wr_rem = '0;
              wr_kcen = 1'b1; top_nxt = top_r + TW'(1);
              pu_nxt = PU_TKEY; ph_nxt = PH_TARRAY;
            end
          end else err = E_MARKER;
        end
        PH_INTMARK: begin
          if (b >= M_INT8 && b <= M_INT64) begin
            size_nxt = 4'd1 << (b[1:0] - 2'd3);
            left_nxt = 64'(4'd1 << (b[1:0] - 2'd3));
            asm_nxt = '0; ph_nxt = PH_INTBYTES;
          end else err = E_INTMARK;
        end
        PH_INTBYTES: begin
          pos = 3'(size_r - left_r[3:0]);
          v = asm_r | (64'(b) << {pos, 3'b000});
          asm_nxt = v;
          left_nxt = left_r - 64'd1;
          if (left_r == 64'd1) begin
            unique case (size_r)
              4'd1: v = {{56{v[7]}}, v[7:0]};
              4'd2: v = {{48{v[15]}}, v[15:0]};
              4'd4: v = {{32{v[31]}}, v[31:0]};
              default: v = v;
            endcase
            ival_nxt = v; iv_nxt = 1'b1; ph_nxt = PH_MARKER;
            if (pu_r == PU_PLAIN) fin = 1'b1;
            else if (v[63]) err = E_NEG;
            else if (pu_r == PU_STR) begin
              if (v == '0) fin = 1'b1;
              else begin left_nxt = v; ph_nxt = PH_SKIP; end
            end else if (pu_r == PU_ARR || pu_r == PU_OBJ) begin
              if (v == '0) fin = 1'b1;
              else if (top_r >= limit) err = E_DEEP;
              else begin
                wr_en = 1'b1; wr_a = AW'(top_r); wr_kcen = 1'b1;
                wr_kind = (pu_r == PU_ARR) ? K_ARR : K_OBJ;
                wr_rem = (pu_r == PU_ARR) ? v : {v[62:0], 1'b0};
                top_nxt = top_r + TW'(1);
              end
            end else if (top_r == '0) err = E_TMPL;
            else if (pu_r == PU_TKEY) begin
              wr_en = 1'b1; wr_rem = v; wr_kc = v; wr_kcen = 1'b1;
              if (v == '0) begin ph_nxt = PH_TARRAY; pu_nxt = PU_TOBJ; end
            end else begin
              mul_nxt = 1'b1; emit = 1'b0;
            end
          end
        end
        PH_SKIP: begin
          left_nxt = left_r - 64'd1;
          if (left_r == 64'd1) fin = 1'b1;
        end
        PH_TARRAY: begin
          if (b == M_ARRAY) ph_nxt = PH_INTMARK;
          else err = E_TMPL;
        end
        PH_DISCARD: begin
          st = ST_DISC;
          if (lst) ph_nxt = PH_MARKER;
        end
        default: err = E_MARKER;
      endcase
    end

    if (fin) begin
      if (top_r == '0) begin
        ph_nxt = PH_MARKER; st = ST_DONE; emit = 1'b1;
      end else begin
        r1 = (trem != '0) ? trem - 64'd1 : trem;
        wr_en = 1'b1; wr_rem = r1;
        if (r1 != '0) begin
          ph_nxt = PH_MARKER; emit = 1'b1;
        end else if (tkind == K_TKEYS) begin
          ph_nxt = PH_TARRAY; pu_nxt = PU_TOBJ; emit = 1'b1;
        end else begin
          top_nxt = top_r - TW'(1); pop_nxt = 1'b1; emit = 1'b0;
        end
      end
    end

    if (emit) begin
      if (st != ST_DISC) begin
        if (err != E_NONE) begin
          st = ST_ERR; top_nxt = '0;
          ph_nxt = lst ? PH_MARKER : PH_DISCARD;
        end else if (st == ST_MORE && lst) begin
          st = ST_ERR; err = E_TRUNC; top_nxt = '0; ph_nxt = PH_MARKER;
        end
      end
      ov_nxt = 1'b1;
      od_nxt.status = st;
      od_nxt.error_code = err;
      od_nxt.nest_level = 5'(top_nxt);
      od_nxt.int_value = (pop_r || mul_r) ? ival_r : ival_nxt;
      od_nxt.int_valid = (pop_r || mul_r) ? iv_r : iv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rem_mem[wr_a]  <= wr_rem;
      kind_mem[wr_a] <= wr_kind;
    end
    if (wr_en && wr_kcen) kc_mem[wr_a] <= wr_kc;
    if (!mul_r) begin
      ma_r   <= ival_nxt;
      mb_r   <= tkc;
      prod_r <= '0;
    end else if (mstep_r != 3'd4) begin
      prod_r <= prod_r + pp_sh;
    end
    od_r   <= od_nxt;
    ival_r <= ival_nxt;
    iv_r   <= iv_nxt;
    asm_r  <= asm_nxt;
    left_r <= left_nxt;
    size_r <= size_nxt;
    last_r <= last_nxt;
  end

  // Hold control state while the partial products accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0; ph_r <= PH_MARKER; pu_r <= PU_PLAIN;
      pop_r <= 1'b0; ov_r <= 1'b0; mul_r <= 1'b0; mstep_r <= '0;
    end else if (mul_r && mstep_r != 3'd4) begin
      mstep_r <= mstep_r + 3'd1;
      ov_r    <= ov_r && !out_ready;
    end else begin
      mstep_r <= '0;
      top_r <= top_nxt; ph_r <= ph_nxt; pu_r <= pu_nxt;
      pop_r <= pop_nxt; ov_r <= ov_nxt;
      mul_r <= mul_nxt;
    end
  end
endmodule
`default_nettype wire
